### rtl/lru_voice_allocator_macros.svh
// Assertion helpers used by the checker file.
`ifndef LRU_VOICE_ALLOCATOR_MACROS_SVH
`define LRU_VOICE_ALLOCATOR_MACROS_SVH

// Concurrent check, disabled while reset is asserted.
`define LVA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lru_voice_allocator check failed");

// Concurrent check that also runs through reset.
`define LVA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("lru_voice_allocator reset check failed");

`endif

### rtl/lva_pkg.sv
package lva_pkg;

    // Event opcodes
    localparam logic OP_NOTE_OFF = 1'b0;
    localparam logic OP_NOTE_ON  = 1'b1;

    // Result action codes
    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_RETRIG  = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_NONE    = 2'd3;

    typedef struct packed {
        logic       opcode;
        logic [3:0] event_chan;
        logic [6:0] note_code;
    } t_in_item;

    typedef struct packed {
        logic [3:0] voice_index;
        logic [1:0] action;
        logic [3:0] out_channel;
        logic [6:0] out_note;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } t_dp_cmd;

endpackage

### rtl/lva_ctrl.sv
module lva_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output lva_pkg::t_dp_cmd o_cmd
);
    import lva_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOKUP = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       slot_free;

    // Result register can take a new result when empty or being drained
    assign slot_free = !r_out_valid || i_out_ready;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cmd.capture = i_in_valid && (r_state == S_IDLE);
    assign o_cmd.lookup  = (r_state == S_LOOKUP);
    assign o_cmd.commit  = (r_state == S_COMMIT) && slot_free;

    // Advance through lookup and commit for each event
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOOKUP;
            end
            S_LOOKUP: n_state = S_COMMIT;
            S_COMMIT: begin
                if (slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Set on commit, drop on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/lva_datapath.sv
module lva_datapath #(
    parameter int VOICE_COUNT = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lva_pkg::t_dp_cmd  i_cmd,
    input  lva_pkg::t_in_item i_in_item,
    output lva_pkg::t_out_item o_out_item
);
    import lva_pkg::*;

    localparam int IW = $clog2(VOICE_COUNT);

    t_in_item            r_evt;
    t_out_item           r_result;
    logic [VOICE_COUNT-1:0] r_hit_vec;
    logic [VOICE_COUNT-1:0] r_voice_valid;
    logic [6:0]          r_voice_note [VOICE_COUNT];
    logic [3:0]          r_voice_chan [VOICE_COUNT];
    logic [IW-1:0]       r_lru [VOICE_COUNT];

    logic                hit_any;
    logic [IW-1:0]       hit_idx;
    logic [IW-1:0]       head;
    logic [IW-1:0]       act_idx;
    logic [IW+3:0]       act_idx_ext;
    logic [IW-1:0]       lru_promo [VOICE_COUNT];
    logic [IW-1:0]       lru_rot [VOICE_COUNT];
    logic                seen;
    t_out_item           n_result;

    assign o_out_item = r_result;
    assign head       = r_lru[0];
    assign hit_any    = |r_hit_vec;

    // Lowest matching voice wins
    always_comb begin
        hit_idx = '0;
        for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
            if (r_hit_vec[v]) hit_idx = IW'(v);
        end
    end

    // Promote the hit voice to the recent end; rotate for a fresh allocation
    always_comb begin
        seen = 1'b0;
        for (int k = 0; k < VOICE_COUNT - 1; k++) begin
            if (r_lru[k] == hit_idx) seen = 1'b1;
            lru_promo[k] = seen ? r_lru[k+1] : r_lru[k];
            lru_rot[k]   = r_lru[k+1];
        end
        lru_promo[VOICE_COUNT-1] = hit_idx;
        lru_rot[VOICE_COUNT-1]   = head;
    end

    // Build the result; a hit or a new load both hold the event's channel and note
    always_comb begin
        act_idx     = (r_evt.opcode == OP_NOTE_ON && !hit_any) ? head : hit_idx;
        act_idx_ext = {4'b0000, act_idx};
        n_result.voice_index = act_idx_ext[3:0];
        n_result.out_channel = r_evt.event_chan;
        n_result.out_note    = r_evt.note_code;
        if (r_evt.opcode == OP_NOTE_ON) begin
            n_result.action = hit_any ? ACT_RETRIG : ACT_START;
        end else if (hit_any) begin
            n_result.action = ACT_RELEASE;
        end else begin
            n_result.action      = ACT_NONE;
            n_result.voice_index = '0;
            n_result.out_channel = '0;
            n_result.out_note    = '0;
        end
    end

    // Hold the event and the match vector between steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_evt <= i_in_item;
        if (i_cmd.lookup) begin
            for (int v = 0; v < VOICE_COUNT; v++) begin
                r_hit_vec[v] <= r_voice_valid[v]
                    && (r_voice_note[v] == r_evt.note_code)
                    && (r_voice_chan[v] == r_evt.event_chan);
            end
        end
        if (i_cmd.commit) r_result <= n_result;
    end

    // Voice table and recency order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice_valid <= '0;
            for (int k = 0; k < VOICE_COUNT; k++) begin
                r_lru[k] <= IW'(k);
            end
        end else if (i_cmd.commit && r_evt.opcode == OP_NOTE_ON) begin
            if (hit_any) begin
                r_lru <= lru_promo;
            end else begin
                r_lru                <= lru_rot;
                r_voice_valid[head]  <= 1'b1;
                r_voice_note[head]   <= r_evt.note_code;
                r_voice_chan[head]   <= r_evt.event_chan;
            end
        end
    end

endmodule

### rtl/lru_voice_allocator.sv
// Assigns synthesizer voices to note events using a least-recently-used order.
// Each accepted event produces exactly one result. An event is taken in the
// idle state, its match against all held voices is registered in the lookup
// state, and the voice table, recency list and result register are updated in
// the commit state, which waits while a previous result is still unread. A note
// off that matches a voice reports release but leaves the voice able to be
// retriggered; one with no match reports no action with all other fields zero.
module lru_voice_allocator #(
    parameter int VOICE_COUNT = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lva_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lva_pkg::t_out_item o_out_item
);
    import lva_pkg::*;

    t_dp_cmd cmd;

    lva_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    lva_datapath #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule

### rtl/lva_checker.sv
`include "lru_voice_allocator_macros.svh"

module lva_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input lva_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input lva_pkg::t_out_item o_out_item
);
    import lva_pkg::*;

    // Stalled result holds
    `LVA_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))

    // No result is pending right after reset
    `LVA_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

    // A no-action result carries zero fields
    `LVA_ASSERT(a_none_zero, i_clk, i_rst_n, o_out_valid && o_out_item.action == ACT_NONE |-> o_out_item.voice_index == 4'd0 && o_out_item.out_channel == 4'd0 && o_out_item.out_note == 7'd0)

    // A new result never appears in the cycle right after an event transfer
    `LVA_ASSERT(a_min_latency, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !$rose(o_out_valid))

endmodule

bind lru_voice_allocator lva_checker u_lva_checker (.*);
